### hdl/pbenc_pkg.sv
// ----------------------------------------------------------------------------
// PackBits row encoder package
// Shared types and constants for the front end, the action queue and the
// byte sequencer.
// ----------------------------------------------------------------------------
package pbenc_pkg;

  // Largest literal or repeat chunk.
  localparam int unsigned CHUNK_MAX = 128;
  localparam int unsigned LIT_IDX_W = $clog2(CHUNK_MAX);
  localparam logic [7:0] CHUNK_MAX8 = 8'(CHUNK_MAX);
  localparam logic [LIT_IDX_W-1:0] LIT_LAST = LIT_IDX_W'(CHUNK_MAX - 1);

  // Literal store: two banks of one chunk each.
  localparam int unsigned RAM_DEPTH = 2 * CHUNK_MAX;
  localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);

  // Row length reporting saturates here.
  localparam int unsigned MAX_OUT_BYTES = 1536;
  localparam logic [10:0] LEN_CAP = 11'((MAX_OUT_BYTES > 2047) ? 2047 : MAX_OUT_BYTES);

  // Action queue between the front end and the sequencer.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Tail bytes that close a row.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_ONE,
    TAIL_PAIR,
    TAIL_TWO
  } tail_e;

  // Everything one input item asks the sequencer to send, in this order:
  // first run, literal chunk, second run, row tail.
  typedef struct packed {
    logic                 run1_en;
    logic [7:0]           run1_len;
    logic                 lit_en;
    logic [7:0]           lit_cnt;
    logic                 lit_bank;
    logic                 run2_en;
    logic [7:0]           run2_len;
    logic [7:0]           run_val;
    tail_e                tail;
    logic [7:0]           tail_b0;
    logic [7:0]           tail_b1;
    logic                 row_end;
    logic                 plane_final;
  } pbenc_entry_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } pbenc_wr_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
  } pbenc_rd_t;

endpackage

### hdl/pbenc_in_if.sv
// ----------------------------------------------------------------------------
// PackBits input channel
// One raw raster byte per beat with row end and last-plane flags.
// ----------------------------------------------------------------------------
interface pbenc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       row_end;
  logic       plane_final;

  modport source (output valid, output data_byte, output row_end, output plane_final,
                  input ready);
  modport sink (input valid, input data_byte, input row_end, input plane_final,
                output ready);
endinterface

### hdl/pbenc_out_if.sv
// ----------------------------------------------------------------------------
// PackBits output channel
// Up to eight encoded bytes per beat with item and row markers.
// ----------------------------------------------------------------------------
interface pbenc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_bytes;
  logic [3:0]  byte_count;
  logic        item_done;
  logic        row_done;
  logic [10:0] row_out_length;
  logic        plane_final_out;

  modport source (output valid, output packed_bytes, output byte_count, output item_done,
                  output row_done, output row_out_length, output plane_final_out,
                  input ready);
  modport sink (input valid, input packed_bytes, input byte_count, input item_done,
                input row_done, input row_out_length, input plane_final_out,
                output ready);
endinterface

### hdl/pbenc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbenc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pbenc_front.sv
// ----------------------------------------------------------------------------
// PackBits front end
// Classifies each raw byte against the lookahead pair and the open run,
// stores literal bytes and queues the chunks the byte completes.
// ----------------------------------------------------------------------------
module pbenc_front import pbenc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pbenc_in_if.sink     in_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output pbenc_entry_t q_entry_o,
  output pbenc_wr_t    ram_wr_o,
  input  logic         lit_done_i
);

  logic [LIT_IDX_W-1:0] lit_fill_q, lit_fill_d;
  logic [7:0]           la0_q, la0_d, la1_q, la1_d;
  logic [1:0]           la_fill_q, la_fill_d;
  logic [7:0]           rep_val_q, rep_val_d;
  logic [7:0]           rep_len_q, rep_len_d;
  logic                 bank_q;
  logic [1:0]           lit_pend_q, lit_pend_d;
  logic                 accept;
  logic                 commit;
  logic [7:0]           b;
  pbenc_entry_t         ent;

  // Two literal chunks may wait for readout; a third would overwrite a bank.
  assign in_i.ready = !q_full_i && (lit_pend_q != 2'd2);
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;

  always_comb begin
    lit_fill_d = lit_fill_q;
    la0_d      = la0_q;
    la1_d      = la1_q;
    la_fill_d  = la_fill_q;
    rep_val_d  = rep_val_q;
    rep_len_d  = rep_len_q;
    commit     = 1'b0;
    ent        = '0;

    if (rep_len_q != 8'd0) begin
      if (b == rep_val_q) begin
        if (rep_len_q == CHUNK_MAX8) begin
          ent.run1_en  = 1'b1;
          ent.run1_len = CHUNK_MAX8;
          rep_len_d    = 8'd1;
        end else begin
          rep_len_d = rep_len_q + 8'd1;
        end
      end else begin
        ent.run1_en  = 1'b1;
        ent.run1_len = rep_len_q;
        rep_len_d    = 8'd0;
        la0_d        = b;
        la_fill_d    = 2'd1;
      end
    end else if (la_fill_q == 2'd2) begin
      if ((la0_q == la1_q) && (la1_q == b)) begin
        // Three equal bytes close the pending literal and open a run.
        if (lit_fill_q != '0) begin
          ent.lit_en  = 1'b1;
          ent.lit_cnt = 8'(lit_fill_q);
          lit_fill_d  = '0;
        end
        rep_val_d = b;
        rep_len_d = 8'd3;
        la_fill_d = 2'd0;
      end else begin
        commit = 1'b1;
        if (lit_fill_q == LIT_LAST) begin
          ent.lit_en  = 1'b1;
          ent.lit_cnt = CHUNK_MAX8;
          lit_fill_d  = '0;
        end else begin
          lit_fill_d = lit_fill_q + 1'b1;
        end
        la0_d = la1_q;
        la1_d = b;
      end
    end else begin
      if (la_fill_q == 2'd0) begin
        la0_d = b;
      end else begin
        la1_d = b;
      end
      la_fill_d = la_fill_q + 2'd1;
    end

    if (in_i.row_end) begin
      if (rep_len_d != 8'd0) begin
        ent.run2_en  = 1'b1;
        ent.run2_len = rep_len_d;
        rep_len_d    = 8'd0;
      end
      if (lit_fill_d != '0) begin
        ent.lit_en  = 1'b1;
        ent.lit_cnt = 8'(lit_fill_d);
        lit_fill_d  = '0;
      end
      if (la_fill_d == 2'd2) begin
        ent.tail = (la0_d == la1_d) ? TAIL_PAIR : TAIL_TWO;
      end else if (la_fill_d == 2'd1) begin
        ent.tail = TAIL_ONE;
      end
      la_fill_d = 2'd0;
    end

    ent.run_val     = rep_val_d;
    ent.lit_bank    = bank_q;
    ent.tail_b0     = la0_d;
    ent.tail_b1     = la1_d;
    ent.row_end     = in_i.row_end;
    ent.plane_final = in_i.plane_final;
  end

  assign q_push_o  = accept && (ent.run1_en || ent.lit_en || ent.run2_en ||
                                (ent.tail != TAIL_NONE));
  assign q_entry_o = ent;

  assign ram_wr_o.en   = accept && commit;
  assign ram_wr_o.addr = {bank_q, lit_fill_q};
  assign ram_wr_o.data = la0_q;

  always_comb begin
    lit_pend_d = lit_pend_q;
    if (q_push_o && ent.lit_en && !lit_done_i) begin
      lit_pend_d = lit_pend_q + 2'd1;
    end else if (!(q_push_o && ent.lit_en) && lit_done_i) begin
      lit_pend_d = lit_pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_fill_q <= '0;
      la_fill_q  <= 2'd0;
      rep_len_q  <= 8'd0;
      bank_q     <= 1'b0;
      lit_pend_q <= 2'd0;
    end else begin
      lit_pend_q <= lit_pend_d;
      if (accept) begin
        lit_fill_q <= lit_fill_d;
        la_fill_q  <= la_fill_d;
        rep_len_q  <= rep_len_d;
        if (ent.lit_en) begin
          bank_q <= !bank_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      la0_q     <= la0_d;
      la1_q     <= la1_d;
      rep_val_q <= rep_val_d;
    end
  end

endmodule

### hdl/pbenc_fifo.sv
// ----------------------------------------------------------------------------
// PackBits action queue
// Short first-in first-out queue of chunk actions between the front end
// and the byte sequencer.
// ----------------------------------------------------------------------------
module pbenc_fifo import pbenc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pbenc_entry_t din_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output pbenc_entry_t dout_o
);

  pbenc_entry_t      slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign dout_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

### hdl/pbenc_back.sv
// ----------------------------------------------------------------------------
// PackBits byte sequencer
// Walks the queued actions one encoded byte per cycle unless a beat stalls,
// reads literal bytes from the store, packs the stream eight bytes to a beat.
// ----------------------------------------------------------------------------
module pbenc_back import pbenc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  pbenc_entry_t q_entry_i,
  output logic         q_pop_o,
  output logic         lit_done_o,
  output pbenc_rd_t    ram_rd_o,
  input  logic [7:0]   ram_rdata_i,
  pbenc_out_if.source  out_o
);

  localparam logic [3:0] P_R1H  = 4'd0;
  localparam logic [3:0] P_R1V  = 4'd1;
  localparam logic [3:0] P_LH   = 4'd2;
  localparam logic [3:0] P_LD   = 4'd3;
  localparam logic [3:0] P_R2H  = 4'd4;
  localparam logic [3:0] P_R2V  = 4'd5;
  localparam logic [3:0] P_T0H  = 4'd6;
  localparam logic [3:0] P_T0B  = 4'd7;
  localparam logic [3:0] P_T1H  = 4'd8;
  localparam logic [3:0] P_T1B  = 4'd9;
  localparam logic [3:0] P_DONE = 4'd10;

  function automatic logic [3:0] from_tail(input pbenc_entry_t e);
    return (e.tail != TAIL_NONE) ? P_T0H : P_DONE;
  endfunction

  function automatic logic [3:0] from_run2(input pbenc_entry_t e);
    return e.run2_en ? P_R2H : from_tail(e);
  endfunction

  function automatic logic [3:0] from_lit(input pbenc_entry_t e);
    return e.lit_en ? P_LH : from_run2(e);
  endfunction

  pbenc_entry_t         e;
  logic                 active_q, active_d;
  logic [3:0]           phase_q, phase_d, nxt;
  logic [LIT_IDX_W-1:0] idx_q, idx_d;
  logic                 lit_end;
  logic [7:0]           byte_val;
  logic                 last, fire, byte_ok, pack_now, out_free;

  logic [63:0] acc_q, acc_d, merged;
  logic [2:0]  acc_cnt_q, acc_cnt_d;
  logic [10:0] len_q, len_d, len_inc;

  logic        ov_q, ov_d;
  logic [63:0] ow_q, ow_d;
  logic [3:0]  oc_q, oc_d;
  logic        oid_q, oid_d, ord_q, ord_d, opf_q, opf_d;
  logic [10:0] olen_q, olen_d;

  assign e       = q_entry_i;
  assign lit_end = (idx_q == LIT_IDX_W'(e.lit_cnt - 8'd1));

  always_comb begin
    byte_val = 8'd0;
    nxt      = P_DONE;
    case (phase_q)
      P_R1H: begin
        byte_val = 8'd1 - e.run1_len;
        nxt      = P_R1V;
      end
      P_R1V: begin
        byte_val = e.run_val;
        nxt      = from_lit(e);
      end
      P_LH: begin
        byte_val = e.lit_cnt - 8'd1;
        nxt      = P_LD;
      end
      P_LD: begin
        byte_val = ram_rdata_i;
        nxt      = lit_end ? from_run2(e) : P_LD;
      end
      P_R2H: begin
        byte_val = 8'd1 - e.run2_len;
        nxt      = P_R2V;
      end
      P_R2V: begin
        byte_val = e.run_val;
        nxt      = from_tail(e);
      end
      P_T0H: begin
        byte_val = (e.tail == TAIL_PAIR) ? 8'hFF : 8'h00;
        nxt      = P_T0B;
      end
      P_T0B: begin
        byte_val = e.tail_b0;
        nxt      = (e.tail == TAIL_TWO) ? P_T1H : P_DONE;
      end
      P_T1H: begin
        byte_val = 8'h00;
        nxt      = P_T1B;
      end
      P_T1B: begin
        byte_val = e.tail_b1;
        nxt      = P_DONE;
      end
      default: begin
        byte_val = 8'd0;
        nxt      = P_DONE;
      end
    endcase
  end

  // A beat leaves the packer on its eighth byte or on the item's last byte;
  // only then does the output register have to be free.
  assign last     = (nxt == P_DONE);
  assign out_free = !ov_q || out_o.ready;
  assign pack_now = (acc_cnt_q == 3'd7) || last;
  assign byte_ok  = !pack_now || out_free;
  assign fire     = active_q && byte_ok;

  assign q_pop_o    = fire && last;
  assign lit_done_o = fire && (phase_q == P_LD) && lit_end;

  // The read for the next literal byte goes out as the current byte leaves,
  // so read data is waiting when the sequencer reaches it.
  assign ram_rd_o.en   = fire && (phase_q inside {P_LH, P_LD});
  assign ram_rd_o.addr = {e.lit_bank,
                          (phase_q == P_LH) ? LIT_IDX_W'(0) : LIT_IDX_W'(idx_q + 1'b1)};

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    if (!active_q) begin
      if (q_valid_i) begin
        active_d = 1'b1;
        phase_d  = e.run1_en ? P_R1H : from_lit(e);
        idx_d    = '0;
      end
    end else if (fire) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        phase_d = nxt;
        if ((phase_q == P_LD) && !lit_end) begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  assign merged  = acc_q | ({56'd0, byte_val} << {acc_cnt_q, 3'b000});
  assign len_inc = (len_q >= LEN_CAP) ? LEN_CAP : (len_q + 11'd1);

  always_comb begin
    acc_d     = acc_q;
    acc_cnt_d = acc_cnt_q;
    len_d     = len_q;
    ov_d      = ov_q && !out_o.ready;
    ow_d      = ow_q;
    oc_d      = oc_q;
    oid_d     = oid_q;
    ord_d     = ord_q;
    olen_d    = olen_q;
    opf_d     = opf_q;
    if (fire) begin
      len_d = len_inc;
      if (pack_now) begin
        ov_d      = 1'b1;
        ow_d      = merged;
        oc_d      = 4'(acc_cnt_q) + 4'd1;
        oid_d     = last;
        ord_d     = last && e.row_end;
        olen_d    = (last && e.row_end) ? len_inc : 11'd0;
        opf_d     = last && e.row_end && e.plane_final;
        acc_d     = 64'd0;
        acc_cnt_d = 3'd0;
        if (last && e.row_end) begin
          len_d = 11'd0;
        end
      end else begin
        acc_d     = merged;
        acc_cnt_d = acc_cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      phase_q   <= P_DONE;
      idx_q     <= '0;
      acc_q     <= 64'd0;
      acc_cnt_q <= 3'd0;
      len_q     <= 11'd0;
      ov_q      <= 1'b0;
    end else begin
      active_q  <= active_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      acc_q     <= acc_d;
      acc_cnt_q <= acc_cnt_d;
      len_q     <= len_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ow_q   <= ow_d;
    oc_q   <= oc_d;
    oid_q  <= oid_d;
    ord_q  <= ord_d;
    olen_q <= olen_d;
    opf_q  <= opf_d;
  end

  assign out_o.valid           = ov_q;
  assign out_o.packed_bytes    = ow_q;
  assign out_o.byte_count      = oc_q;
  assign out_o.item_done       = oid_q;
  assign out_o.row_done        = ord_q;
  assign out_o.row_out_length  = olen_q;
  assign out_o.plane_final_out = opf_q;

endmodule

### hdl/packbits_row_encoder_unit.sv
// ----------------------------------------------------------------------------
// PackBits row encoder
// Run-length codes raster rows into a PackBits byte stream, eight bytes
// to an output beat.
// ----------------------------------------------------------------------------
// The input takes one raw byte per cycle as long as the four-entry action
// queue has room and fewer than two literal chunks wait for readout. Each
// byte is classified at once; the chunks it completes go into the queue
// and the sequencer behind it sends them at one encoded byte per cycle
// while the output register can take a finished beat, with a load step
// for each queued action group. The sequencer therefore sets the
// sustained rate, with the queue and the two-bank literal store absorbing
// bursts. The output register lets the packer carry on while a finished
// beat waits. The beat carrying row_done also carries the row's encoded
// length, saturated at the package limit.
// ----------------------------------------------------------------------------
module packbits_row_encoder_unit import pbenc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pbenc_in_if.sink     in_i,
  pbenc_out_if.source  out_o
);

  logic         q_full, q_push, q_pop, q_valid, lit_done;
  pbenc_entry_t q_din, q_dout;
  pbenc_wr_t    ram_wr;
  pbenc_rd_t    ram_rd;
  logic [7:0]   ram_rdata;

  pbenc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_din),
    .ram_wr_o   (ram_wr),
    .lit_done_i (lit_done)
  );

  pbenc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .dout_o  (q_dout)
  );

  pbenc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_lit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_rd.en),
    .raddr_i (ram_rd.addr),
    .rdata_o (ram_rdata)
  );

  pbenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_dout),
    .q_pop_o     (q_pop),
    .lit_done_o  (lit_done),
    .ram_rd_o    (ram_rd),
    .ram_rdata_i (ram_rdata),
    .out_o       (out_o)
  );

  // The front end must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("action pushed into a full queue");

  // Only the last beat of an item may be short.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.byte_count != 4'd8) |-> out_o.item_done)
    else $error("short beat before the end of an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.byte_count != 4'd0) && (out_o.byte_count <= 4'd8))
    else $error("beat byte count out of range");

  // Row markers and length belong to the item's last beat only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.item_done |->
      !out_o.row_done && (out_o.row_out_length == 11'd0) && !out_o.plane_final_out)
    else $error("row fields set on an inner beat");

endmodule

### verif/packbits_row_encoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PackBits row encoder unit test
// Drives raster rows into the encoder and keeps a running model of the
// PackBits coder alongside it. Every byte accepted at the input adds the
// beats that it should cause to a queue. Each beat leaving the encoder is
// compared field by field against the head of that queue. Directed rows
// cover the row tails and full literal and repeat chunks. Random rows then
// run under changing sender gaps and receiver stalls, including one long
// receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module packbits_row_encoder_unit_test;
  import pbenc_pkg::*;

  typedef logic [7:0] row_q_t[$];

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        item_last;
    logic        row_last;
    logic [10:0] row_len;
    logic        plane_last;
  } enc_beat_t;

  logic clk_i;
  logic rst_ni;

  pbenc_in_if  in_if();
  pbenc_out_if out_if();

  packbits_row_encoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Encoder state as the coder sees it between bytes.
  logic [7:0]  lit_buf [CHUNK_MAX];
  int unsigned lit_cnt = 0;
  logic [7:0]  hold_bytes [2];
  int unsigned hold_cnt = 0;
  logic [7:0]  run_byte = 8'h00;
  int unsigned run_len = 0;
  int unsigned row_total = 0;
  logic [7:0]  code_bytes[$];

  enc_beat_t   expected_beats[$];
  int unsigned err_count = 0;
  int unsigned beat_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold = 0;

  function automatic void send_literals();
    if (lit_cnt == 0) return;
    code_bytes.push_back(8'(lit_cnt - 1));
    for (int unsigned i = 0; i < lit_cnt; i++) code_bytes.push_back(lit_buf[i]);
    lit_cnt = 0;
  endfunction

  function automatic void send_run(int unsigned len);
    code_bytes.push_back(8'(257 - len));
    code_bytes.push_back(run_byte);
  endfunction

  function automatic void add_literal(logic [7:0] b);
    lit_buf[lit_cnt % CHUNK_MAX] = b;
    lit_cnt++;
    if (lit_cnt >= CHUNK_MAX) send_literals();
  endfunction

  // Advances the coder by one raw byte and queues the beats it produces.
  function automatic void packbits_encode(logic [7:0] b, logic re, logic pf);
    enc_beat_t   beat;
    int unsigned n;
    int unsigned nres;
    int unsigned cnt;
    int unsigned sum;
    code_bytes.delete();
    if (run_len != 0) begin
      if (b == run_byte) begin
        // A full run is held until the next byte shows whether it goes on.
        if (run_len >= CHUNK_MAX) begin
          send_run(CHUNK_MAX);
          run_len = 1;
        end else begin
          run_len++;
        end
      end else begin
        send_run(run_len);
        run_len = 0;
        hold_bytes[0] = b;
        hold_cnt = 1;
      end
    end else if (hold_cnt >= 2) begin
      if (hold_bytes[0] == hold_bytes[1] && hold_bytes[1] == b) begin
        send_literals();
        run_byte = b;
        run_len = 3;
        hold_cnt = 0;
      end else begin
        add_literal(hold_bytes[0]);
        hold_bytes[0] = hold_bytes[1];
        hold_bytes[1] = b;
      end
    end else begin
      hold_bytes[hold_cnt % 2] = b;
      hold_cnt++;
    end

    if (re) begin
      if (run_len != 0) begin
        send_run(run_len);
        run_len = 0;
      end
      send_literals();
      if (hold_cnt >= 2) begin
        if (hold_bytes[0] == hold_bytes[1]) begin
          code_bytes.push_back(8'hFF);
          code_bytes.push_back(hold_bytes[0]);
        end else begin
          code_bytes.push_back(8'h00);
          code_bytes.push_back(hold_bytes[0]);
          code_bytes.push_back(8'h00);
          code_bytes.push_back(hold_bytes[1]);
        end
      end else if (hold_cnt == 1) begin
        code_bytes.push_back(8'h00);
        code_bytes.push_back(hold_bytes[0]);
      end
      hold_cnt = 0;
    end

    n = code_bytes.size();
    sum = row_total + n;
    row_total = (sum > LEN_CAP) ? LEN_CAP : sum;
    nres = (n + 7) / 8;
    for (int unsigned k = 0; k < nres; k++) begin
      beat = '0;
      cnt = n - k * 8;
      if (cnt > 8) cnt = 8;
      for (int unsigned j = 0; j < cnt; j++) beat.bytes[8*j +: 8] = code_bytes[k*8 + j];
      beat.count = 4'(cnt);
      beat.item_last = (k + 1 == nres);
      beat.row_last = beat.item_last && re;
      beat.row_len = beat.row_last ? 11'(row_total) : 11'd0;
      beat.plane_last = beat.row_last ? pf : 1'b0;
      expected_beats.push_back(beat);
    end
    if (re) row_total = 0;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 100) $display("MISMATCH %0t ns beat %0d: %s", $time, beat_count, msg);
  endtask

  task automatic check_beat();
    enc_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("output beat with no prediction pending");
      return;
    end
    want = expected_beats.pop_front();
    if (out_if.packed_bytes !== want.bytes)
      report_mismatch($sformatf("packed_bytes %h, want %h", out_if.packed_bytes, want.bytes));
    if (out_if.byte_count !== want.count)
      report_mismatch($sformatf("byte_count %0d, want %0d", out_if.byte_count, want.count));
    if (out_if.item_done !== want.item_last)
      report_mismatch($sformatf("item_done %b, want %b", out_if.item_done, want.item_last));
    if (out_if.row_done !== want.row_last)
      report_mismatch($sformatf("row_done %b, want %b", out_if.row_done, want.row_last));
    if (out_if.row_out_length !== want.row_len)
      report_mismatch($sformatf("row_out_length %0d, want %0d", out_if.row_out_length,
                                want.row_len));
    if (out_if.plane_final_out !== want.plane_last)
      report_mismatch($sformatf("plane_final_out %b, want %b", out_if.plane_final_out,
                                want.plane_last));
    beat_count++;
  endtask

  // Output side: checks each accepted beat and paces ready.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_beat();
      if (recv_hold != 0) begin
        out_if.ready <= 1'b0;
        recv_hold--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one raw byte and returns at the edge where it is taken.
  task automatic send_byte(logic [7:0] b, logic re, logic pf);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.row_end <= re;
    in_if.plane_final <= pf;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    packbits_encode(b, re, pf);
  endtask

  task automatic send_row(row_q_t row, logic pf);
    for (int i = 0; i < row.size(); i++) send_byte(row[i], i == row.size() - 1, pf);
  endtask

  // Random byte that never makes three equal bytes in a row.
  function automatic logic [7:0] no_run_byte(logic [7:0] p1, logic [7:0] p2);
    logic [7:0] b;
    b = 8'($urandom);
    if (b == p1 && p1 == p2) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic row_q_t literal_row(int n);
    row_q_t row;
    for (int i = 0; i < n; i++)
      row.push_back(no_run_byte(i > 0 ? row[i-1] : 8'h00, i > 1 ? row[i-2] : 8'h01));
    return row;
  endfunction

  // Short rows: single byte, pair tails, run of three, run after literal.
  task automatic test_row_tails();
    send_row('{8'h00}, 1'b1);
    send_row('{8'hFF}, 1'b0);
    send_row('{8'hFF, 8'hFF}, 1'b0);
    send_row('{8'h00, 8'hFF}, 1'b1);
    send_row('{8'hA5, 8'hA5, 8'hA5}, 1'b1);
    send_row('{8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04, 8'h04}, 1'b0);
    send_row('{8'h09, 8'h09, 8'h09, 8'h09, 8'h05}, 1'b1);
    send_row('{8'h80, 8'h80, 8'h7F}, 1'b0);
  endtask

  // One row with a full literal chunk and a remainder, then a run one past
  // a full repeat chunk, so the held chunk goes out on the next equal byte.
  task automatic test_full_chunks();
    row_q_t     row;
    logic [7:0] val;
    row = literal_row(CHUNK_MAX + 1);
    val = row[row.size() - 1] ^ 8'h80;
    repeat (CHUNK_MAX + 1) row.push_back(val);
    send_row(row, 1'b1);
  endtask

  // Rows built from runs and short literals.
  task automatic test_random_rows(int unsigned items);
    row_q_t      row;
    int unsigned sent;
    int unsigned len;
    int unsigned seg;
    logic [7:0]  val;
    sent = 0;
    while (sent < items) begin
      row.delete();
      len = $urandom_range(1, 16);
      while (row.size() < len) begin
        if ($urandom_range(2) == 0) begin
          seg = $urandom_range(2, 8);
          val = 8'($urandom);
          repeat (seg) row.push_back(val);
        end else begin
          repeat ($urandom_range(1, 6))
            row.push_back($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(3)));
        end
      end
      while (row.size() > len) void'(row.pop_back());
      send_row(row, 1'($urandom));
      sent += len;
    end
  endtask

  // The receiver holds off while bytes keep coming, so the input stalls.
  task automatic test_output_backpressure();
    recv_hold = 300;
    test_random_rows(28);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.row_end <= 1'b0;
    in_if.plane_final <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_row_tails();
    test_full_chunks();

    test_random_rows(6);
    send_idle_pct = 61;
    test_random_rows(6);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    test_random_rows(6);
    send_idle_pct = 32;
    recv_stall_pct = 32;
    test_random_rows(6);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_output_backpressure();

    in_if.valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_count == 0 && expected_beats.size() == 0) begin
      $display("** packbits_row_encoder_unit: PASSED **");
    end else begin
      $display("** packbits_row_encoder_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("** packbits_row_encoder_unit: FAILED **");
    $finish;
  end

endmodule

### files.f
hdl/pbenc_pkg.sv
hdl/pbenc_in_if.sv
hdl/pbenc_out_if.sv
hdl/pbenc_ram.sv
hdl/pbenc_front.sv
hdl/pbenc_fifo.sv
hdl/pbenc_back.sv
hdl/packbits_row_encoder_unit.sv
verif/packbits_row_encoder_unit_test.sv
